/* sv/icr_pkg.sv */
// ----------------------------------------------------------------------------
// icr_pkg
// Types, constants and arithmetic helpers for the impulse collision response.
// ----------------------------------------------------------------------------
package icr_pkg;

	localparam int unsigned NSTAGE    = 19;
	localparam int unsigned DIV_STG   = 8;
	localparam int unsigned DIV_BITS  = 4;
	localparam logic [15:0] REST_RST  = 16'd13107;

	// payload carried alongside the arithmetic through stages s1 to s18
	typedef struct packed {
		logic [2:0][31:0] n;
		logic [2:0][31:0] va;
		logic [2:0][31:0] vb;
		logic [30:0]      ima;
		logic [30:0]      imb;
		logic [31:0]      den;
		logic             fault;
	} carry_t;

	// one slice of the pipelined restoring divider
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] lo;
		logic        ovf;
		logic        neg;
	} div_t;

	// saturate to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [63:0] mx;
		logic signed [63:0] mn;
		mx = 64'sh0000_0000_7FFF_FFFF;
		mn = -64'sh0000_0000_8000_0000;
		if (x > mx)
			sat32 = 32'sh7FFF_FFFF;
		else if (x < mn)
			sat32 = 32'sh8000_0000;
		else
			sat32 = x[31:0];
	endfunction

	// four quotient bits of restoring division
	function automatic div_t div_step4(input div_t d, input logic [31:0] den);
		div_t        r;
		logic [32:0] t;
		r = d;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, r.lo[31]};
			r.lo = {r.lo[30:0], 1'b0};
			if (t >= {1'b0, den}) begin
				r.rem = 32'(t - {1'b0, den});
				r.quo = {r.quo[30:0], 1'b1};
			end else begin
				r.rem = t[31:0];
				r.quo = {r.quo[30:0], 1'b0};
			end
		end
		div_step4 = r;
	endfunction

endpackage

/* sv/icr_if.sv */
// ----------------------------------------------------------------------------
// icr_col_if / icr_res_if
// Valid/ready channels for collision records and velocity results.
// ----------------------------------------------------------------------------
interface icr_col_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] normal_x;
	logic signed [31:0] normal_y;
	logic signed [31:0] normal_z;
	logic signed [31:0] vel_a_x;
	logic signed [31:0] vel_a_y;
	logic signed [31:0] vel_a_z;
	logic signed [31:0] vel_b_x;
	logic signed [31:0] vel_b_y;
	logic signed [31:0] vel_b_z;
	logic [30:0]        inv_mass_a;
	logic [30:0]        inv_mass_b;

	modport source (output valid, normal_x, normal_y, normal_z, vel_a_x, vel_a_y, vel_a_z,
		vel_b_x, vel_b_y, vel_b_z, inv_mass_a, inv_mass_b, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, vel_a_x, vel_a_y, vel_a_z,
		vel_b_x, vel_b_y, vel_b_z, inv_mass_a, inv_mass_b, output ready);
endinterface

interface icr_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_vel_a_x;
	logic signed [31:0] new_vel_a_y;
	logic signed [31:0] new_vel_a_z;
	logic signed [31:0] new_vel_b_x;
	logic signed [31:0] new_vel_b_y;
	logic signed [31:0] new_vel_b_z;
	logic               div_fault;

	modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_a_z, new_vel_b_x,
		new_vel_b_y, new_vel_b_z, div_fault, input ready);
	modport sink (input valid, new_vel_a_x, new_vel_a_y, new_vel_a_z, new_vel_b_x,
		new_vel_b_y, new_vel_b_z, div_fault, output ready);
endinterface

/* sv/impulse_collision_response.sv */
// ----------------------------------------------------------------------------
// impulse_collision_response
// Throughput: one collision per cycle; a stage stalls only when it holds
// data and the stage after it is stalled.
// The impulse divide is a restoring divider of 8 stages, 4 quotient bits each.
// Reset clears all stage valid bits and sets restitution to 0.2 (13107).
// ----------------------------------------------------------------------------
module impulse_collision_response (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	icr_col_if.sink     col,
	icr_res_if.source   res
);
	import icr_pkg::*;

	logic [15:0]         rest_q;
	logic [NSTAGE-1:0]   vld_q;
	logic [NSTAGE-1:0]   en;

	carry_t              carry_s1, carry_s2, carry_s3, carry_s4, carry_s5, carry_s6;
	carry_t              carry_sd [DIV_STG];
	carry_t              carry_s15, carry_s16, carry_s17, carry_s18;
	logic signed [63:0]  pra_s2 [3];
	logic signed [63:0]  prb_s2 [3];
	logic signed [51:0]  dv_s3, dv_s4;
	logic signed [68:0]  dvr_s4;
	logic                neg_s5;
	logic [50:0]         mag_s5;
	div_t                div_s6;
	div_t                div_sd [DIV_STG];
	div_t                div_nx [DIV_STG];
	logic signed [31:0]  imp_s15;
	logic signed [63:0]  pma_s16, pmb_s16;
	logic signed [31:0]  sa_s17, sb_s17;
	logic signed [63:0]  dva_s18 [3];
	logic signed [63:0]  dvb_s18 [3];
	logic [2:0][31:0]    na_s19, nb_s19;
	logic                fault_s19;

	// restitution register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rest_q <= REST_RST;
		else if (cfg_we)
			rest_q <= cfg_wdata;
	end

	// stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NSTAGE-1] = !vld_q[NSTAGE-1] || res.ready;
		for (int k = NSTAGE - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign col.ready = en[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= col.valid;
			for (int k = 1; k < NSTAGE; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// s1: capture transaction
	always_ff @(posedge clk) begin
		if (en[0]) begin
			carry_s1.n     <= {col.normal_z, col.normal_y, col.normal_x};
			carry_s1.va    <= {col.vel_a_z, col.vel_a_y, col.vel_a_x};
			carry_s1.vb    <= {col.vel_b_z, col.vel_b_y, col.vel_b_x};
			carry_s1.ima   <= col.inv_mass_a;
			carry_s1.imb   <= col.inv_mass_b;
			carry_s1.den   <= {1'b0, col.inv_mass_a} + {1'b0, col.inv_mass_b};
			carry_s1.fault <= (col.inv_mass_a == '0) && (col.inv_mass_b == '0);
		end
	end

	// s2: projection products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			carry_s2 <= carry_s1;
			for (int i = 0; i < 3; i++) begin
				pra_s2[i] <= $signed(carry_s1.n[i]) * $signed(carry_s1.va[i]);
				prb_s2[i] <= $signed(carry_s1.n[i]) * $signed(carry_s1.vb[i]);
			end
		end
	end

	// s3: relative normal velocity
	always_ff @(posedge clk) begin
		if (en[2]) begin
			carry_s3 <= carry_s2;
			dv_s3 <= 52'(pra_s2[0] >>> 16) + 52'(pra_s2[1] >>> 16) + 52'(pra_s2[2] >>> 16)
				- 52'(prb_s2[0] >>> 16) - 52'(prb_s2[1] >>> 16) - 52'(prb_s2[2] >>> 16);
		end
	end

	// s4: restitution product
	always_ff @(posedge clk) begin
		if (en[3]) begin
			carry_s4 <= carry_s3;
			dv_s4    <= dv_s3;
			dvr_s4   <= 69'(dv_s3 * $signed({1'b0, rest_q}));
		end
	end

	// s5: numerator sign and magnitude
	logic signed [52:0] num_c;
	assign num_c = 53'(dv_s4) + 53'(dvr_s4 >>> 16);
	always_ff @(posedge clk) begin
		if (en[4]) begin
			carry_s5 <= carry_s4;
			neg_s5   <= num_c > 0;
			mag_s5   <= num_c[52] ? 51'(-num_c) : num_c[50:0];
		end
	end

	// s6: overflow check and divider seed
	always_ff @(posedge clk) begin
		if (en[5]) begin
			carry_s6   <= carry_s5;
			div_s6.ovf <= {1'b0, mag_s5} >= {4'b0, carry_s5.den, 16'b0};
			div_s6.neg <= neg_s5;
			div_s6.rem <= mag_s5[47:16];
			div_s6.quo <= '0;
			div_s6.lo  <= {mag_s5[15:0], 16'b0};
		end
	end

	// divider stages
	always_comb begin
		div_nx[0] = div_step4(div_s6, carry_s6.den);
		for (int j = 1; j < DIV_STG; j++)
			div_nx[j] = div_step4(div_sd[j-1], carry_sd[j-1].den);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			div_sd[0]   <= div_nx[0];
			carry_sd[0] <= carry_s6;
		end
		for (int j = 1; j < DIV_STG; j++) begin
			if (en[6+j]) begin
				div_sd[j]   <= div_nx[j];
				carry_sd[j] <= carry_sd[j-1];
			end
		end
	end

	// s15: saturate quotient and apply sign
	logic [32:0] lim_c, q_c;
	always_comb begin
		lim_c = div_sd[DIV_STG-1].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		q_c   = {1'b0, div_sd[DIV_STG-1].quo};
		if (div_sd[DIV_STG-1].ovf || q_c > lim_c)
			q_c = lim_c;
	end
	always_ff @(posedge clk) begin
		if (en[14]) begin
			carry_s15 <= carry_sd[DIV_STG-1];
			imp_s15   <= div_sd[DIV_STG-1].neg ? 32'(-q_c) : q_c[31:0];
		end
	end

	// s16: impulse times inverse masses
	always_ff @(posedge clk) begin
		if (en[15]) begin
			carry_s16 <= carry_s15;
			pma_s16   <= 64'(imp_s15 * $signed({1'b0, carry_s15.ima}));
			pmb_s16   <= 64'(imp_s15 * $signed({1'b0, carry_s15.imb}));
		end
	end

	// s17: scaled impulses
	always_ff @(posedge clk) begin
		if (en[16]) begin
			carry_s17 <= carry_s16;
			sa_s17    <= sat32(pma_s16 >>> 16);
			sb_s17    <= sat32(pmb_s16 >>> 16);
		end
	end

	// s18: per axis velocity change
	always_ff @(posedge clk) begin
		if (en[17]) begin
			carry_s18 <= carry_s17;
			for (int i = 0; i < 3; i++) begin
				dva_s18[i] <= $signed(carry_s17.n[i]) * sa_s17;
				dvb_s18[i] <= $signed(carry_s17.n[i]) * sb_s17;
			end
		end
	end

	// s19: apply, saturate, output register
	always_ff @(posedge clk) begin
		if (en[18]) begin
			fault_s19 <= carry_s18.fault;
			for (int i = 0; i < 3; i++) begin
				if (carry_s18.fault) begin
					na_s19[i] <= carry_s18.va[i];
					nb_s19[i] <= carry_s18.vb[i];
				end else begin
					na_s19[i] <= sat32(64'($signed(carry_s18.va[i])) + (dva_s18[i] >>> 16));
					nb_s19[i] <= sat32(64'($signed(carry_s18.vb[i])) - (dvb_s18[i] >>> 16));
				end
			end
		end
	end

	assign res.valid       = vld_q[NSTAGE-1];
	assign res.new_vel_a_x = na_s19[0];
	assign res.new_vel_a_y = na_s19[1];
	assign res.new_vel_a_z = na_s19[2];
	assign res.new_vel_b_x = nb_s19[0];
	assign res.new_vel_b_y = nb_s19[1];
	assign res.new_vel_b_z = nb_s19[2];
	assign res.div_fault   = fault_s19;

	// input is held off only when every stage is occupied
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!col.ready |-> (&vld_q))
		else $error("input stalled with a bubble in the pipeline");

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(na_s19) && $stable(nb_s19))
		else $error("result changed while stalled");

	// a body with zero inverse mass receives no impulse
	a_zero_mass: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[16] && (carry_s17.ima == '0) |-> (sa_s17 == '0))
		else $error("nonzero impulse on an immovable body");

endmodule
